[rtl/lpht_pkg.sv]
`default_nettype none

package lpht_pkg;

  // default table depth
  localparam int unsigned TABLE_SIZE_DEF = 16;

  // field widths
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned PROBE_W = 11;

  // home slot reduction: reciprocal multiply, quotient times size, subtract
  localparam int unsigned MOD_STEPS = 3;
  localparam int unsigned MOD_CNT_W = 2;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_FOUND     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HOME,
    S_PROBE,
    S_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic set_full;
    logic mod_step;
    logic probe_start;
    logic probe;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic full_insert;
    logic mod_last;
    logic probe_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/lpht_ram.sv]
`default_nettype none

module lpht_ram #(
  parameter int unsigned Width     = 8,
  parameter int unsigned Depth     = 16,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/lpht_ctrl.sv]
`default_nettype none

module lpht_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lpht_pkg::dp_stat_t  stat_i,
  output lpht_pkg::ctrl_cmd_t      cmd_o
);

  lpht_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lpht_pkg::S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end
      lpht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.full_insert) begin
            cmd_o.set_full = 1'b1;
            state_d        = lpht_pkg::S_EMIT;
          end else begin
            state_d = lpht_pkg::S_MOD;
          end
        end
      end
      lpht_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = lpht_pkg::S_HOME;
        end
      end
      lpht_pkg::S_HOME: begin
        cmd_o.probe_start = 1'b1;
        state_d           = lpht_pkg::S_PROBE;
      end
      lpht_pkg::S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (stat_i.probe_done) begin
          state_d = lpht_pkg::S_EMIT;
        end
      end
      lpht_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpht_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/lpht_dp.sv]
`default_nettype none

module lpht_dp #(
  parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lpht_pkg::ctrl_cmd_t          cmd_i,
  output lpht_pkg::dp_stat_t                stat_o,
  input  wire logic                         kind_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lpht_pkg::NAME_W-1:0]  name_tag_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic                         cfg_data_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [1:0]                        status_o,
  output logic [lpht_pkg::NAME_W-1:0]       found_name_o,
  output logic [lpht_pkg::SLOT_W-1:0]       slot_o,
  output logic [lpht_pkg::PROBE_W-1:0]      probe_count_o
);

  localparam int unsigned SW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned DW = SW + lpht_pkg::KEY_W + lpht_pkg::NAME_W;
  localparam logic [SW-1:0] LastPos = SW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] FullCnt = CW'(TABLE_SIZE);
  localparam logic [lpht_pkg::MOD_CNT_W-1:0] ModLast =
    lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1);

  // reciprocal of the table size, exact quotient for every key
  localparam int unsigned RW         = lpht_pkg::KEY_W + 1;
  localparam int unsigned PW         = lpht_pkg::KEY_W + RW;
  localparam int unsigned RecipShift = lpht_pkg::KEY_W + SW;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipShift) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RW-1:0] Recip = RW'(RecipFull);
  localparam logic [lpht_pkg::KEY_W-1:0] NKey = lpht_pkg::KEY_W'(TABLE_SIZE);

  // item and probe registers
  logic                        kind_q;
  logic [lpht_pkg::KEY_W-1:0]  car_key_q;
  logic [lpht_pkg::NAME_W-1:0] car_name_q;
  logic [SW-1:0]               car_home_q;
  logic                        displaced_q;
  logic [PW-1:0]               prod_q;
  logic [lpht_pkg::KEY_W-1:0]  qn_q;
  logic [SW-1:0]               rem_q;
  logic [lpht_pkg::MOD_CNT_W-1:0] mcnt_q;
  logic [SW-1:0]               pos_q;
  logic [SW-1:0]               off_q;
  logic [CW-1:0]               cnt_q;
  logic                        replace_q;

  // pending result
  logic [1:0]                   res_status_q, res_status_d;
  logic [lpht_pkg::NAME_W-1:0]  res_name_q, res_name_d;
  logic [lpht_pkg::SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic [lpht_pkg::PROBE_W-1:0] res_probe_q, res_probe_d;

  // output register
  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic [lpht_pkg::NAME_W-1:0]  out_name_q;
  logic [lpht_pkg::SLOT_W-1:0]  out_slot_q;
  logic [lpht_pkg::PROBE_W-1:0] out_probe_q;

  // memory ports
  logic          we;
  logic [SW-1:0] rd_addr;
  logic [DW-1:0] wr_data;
  logic          wr_valid;
  logic [DW-1:0] rd_data;
  logic          rd_valid;

  logic [SW-1:0]               pos_next;
  logic [SW-1:0]               rd_home;
  logic [lpht_pkg::KEY_W-1:0]  rd_key;
  logic [lpht_pkg::NAME_W-1:0] rd_name;
  logic                        done;
  logic                        adv;
  logic                        disp;
  logic                        last_off;
  logic                        stored;
  logic [PW-1:0]               prod_sh;
  logic [lpht_pkg::KEY_W-1:0]  quot;
  logic [lpht_pkg::KEY_W-1:0]  rem_full;

  assign pos_next = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
  assign rd_addr  = cmd_i.probe_start ? rem_q : pos_next;
  assign rd_home  = rd_data[DW-1 -: SW];
  assign rd_key   = rd_data[lpht_pkg::NAME_W +: lpht_pkg::KEY_W];
  assign rd_name  = rd_data[lpht_pkg::NAME_W-1:0];
  assign last_off = (off_q == LastPos);

  // key mod table size: quotient from the reciprocal, then subtract
  assign prod_sh  = prod_q >> RecipShift;
  assign quot     = prod_sh[lpht_pkg::KEY_W-1:0];
  assign rem_full = car_key_q - qn_q;

  lpht_ram #(
    .Width (DW),
    .Depth (TABLE_SIZE)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lpht_ram #(
    .Width (1),
    .Depth (TABLE_SIZE)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wr_valid),
    .raddr_i (rd_addr),
    .rdata_o (rd_valid)
  );

  // probe decision and table writes
  always_comb begin
    we           = 1'b0;
    wr_valid     = 1'b1;
    wr_data      = {car_home_q, car_key_q, car_name_q};
    done         = 1'b0;
    adv          = 1'b0;
    disp         = 1'b0;
    stored       = 1'b0;
    res_status_d = lpht_pkg::STAT_FULL;
    res_name_d   = '0;
    res_slot_d   = '0;
    res_probe_d  = '0;
    if (cmd_i.clr) begin
      we       = 1'b1;
      wr_valid = 1'b0;
    end
    if (cmd_i.probe) begin
      if (kind_q == lpht_pkg::KIND_SEARCH) begin
        if (rd_valid && (rd_key == car_key_q)) begin
          done         = 1'b1;
          res_status_d = lpht_pkg::STAT_FOUND;
          res_name_d   = rd_name;
          res_slot_d   = lpht_pkg::SLOT_W'(pos_q);
          res_probe_d  = lpht_pkg::PROBE_W'(off_q) + 1'b1;
        end else if (last_off) begin
          done         = 1'b1;
          res_status_d = lpht_pkg::STAT_NOT_FOUND;
          res_probe_d  = lpht_pkg::PROBE_W'(TABLE_SIZE + 1);
        end else begin
          adv = 1'b1;
        end
      end else begin
        if (!rd_valid) begin
          we           = 1'b1;
          done         = 1'b1;
          stored       = 1'b1;
          res_status_d = lpht_pkg::STAT_INSERTED;
          res_slot_d   = lpht_pkg::SLOT_W'(displaced_q ? car_home_q : pos_q);
          if (displaced_q) begin
            res_slot_d = lpht_pkg::SLOT_W'(rem_q);
          end
          res_probe_d  = (off_q == '0) ? '0 : lpht_pkg::PROBE_W'(off_q) + 1'b1;
        end else if (last_off) begin
          // no empty slot left: cannot happen below the full count
          done = 1'b1;
        end else begin
          adv = 1'b1;
          // misplaced home occupant gives way to the new entry
          if ((off_q == '0) && replace_q && (rd_home != rem_q)) begin
            we   = 1'b1;
            disp = 1'b1;
          end
        end
      end
    end
  end

  // status to controller
  always_comb begin
    stat_o.clr_last    = (pos_q == LastPos);
    stat_o.full_insert = (kind_i == lpht_pkg::KIND_INSERT) && (cnt_q == FullCnt);
    stat_o.mod_last    = (mcnt_q == ModLast);
    stat_o.probe_done  = done;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      replace_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        replace_q <= cfg_data_i;
      end
      if (cmd_i.clr || adv) begin
        pos_q <= pos_next;
      end else if (cmd_i.probe_start) begin
        pos_q <= rem_q;
      end
      if (stored) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture, home slot reduction and probe walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      car_key_q  <= key_i;
      car_name_q <= name_tag_i;
      mcnt_q     <= '0;
    end
    // three step pipeline, the remainder is settled after the last step
    if (cmd_i.mod_step) begin
      prod_q <= PW'(car_key_q) * PW'(Recip);
      qn_q   <= quot * NKey;
      rem_q  <= rem_full[SW-1:0];
      mcnt_q <= mcnt_q + 1'b1;
    end
    if (cmd_i.probe_start) begin
      car_home_q  <= rem_q;
      displaced_q <= 1'b0;
      off_q       <= '0;
    end
    if (adv) begin
      off_q <= off_q + 1'b1;
    end
    if (disp) begin
      car_home_q  <= rd_home;
      car_key_q   <= rd_key;
      car_name_q  <= rd_name;
      displaced_q <= 1'b1;
    end
    if (cmd_i.set_full || done) begin
      res_status_q <= cmd_i.set_full ? lpht_pkg::STAT_FULL : res_status_d;
      res_name_q   <= cmd_i.set_full ? '0 : res_name_d;
      res_slot_q   <= cmd_i.set_full ? '0 : res_slot_d;
      res_probe_q  <= cmd_i.set_full ? '0 : res_probe_d;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_name_q   <= res_name_q;
      out_slot_q   <= res_slot_q;
      out_probe_q  <= res_probe_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_name_o  = out_name_q;
  assign slot_o        = out_slot_q;
  assign probe_count_o = out_probe_q;

endmodule

`default_nettype wire

[rtl/linear_probe_hash_table_core.sv]
// result path: full-table insert goes straight to S_EMIT; other items pass
//   S_MOD, S_HOME, S_PROBE (1 to TABLE_SIZE slots probed), then S_EMIT
// throughput: one item at a time; S_EMIT waits for a free output register,
//   next beat taken once the result has moved there
// reset: S_CLEAR clears the valid bit of every slot after reset, no input
//   beat taken meanwhile; replace_mode resets to 0
`default_nettype none

module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lpht_pkg::NAME_W-1:0]  name_tag_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        status_o,
  output logic [lpht_pkg::NAME_W-1:0]       found_name_o,
  output logic [lpht_pkg::SLOT_W-1:0]       slot_o,
  output logic [lpht_pkg::PROBE_W-1:0]      probe_count_o
);

  lpht_pkg::ctrl_cmd_t cmd;
  lpht_pkg::dp_stat_t  stat;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, probe walk and result registers
  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .name_tag_i    (name_tag_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .found_name_o  (found_name_o),
    .slot_o        (slot_o),
    .probe_count_o (probe_count_o)
  );

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;

  localparam int unsigned SLOTS = lpht_pkg::TABLE_SIZE_DEF;
  localparam int HALF_PERIOD = 6;

  // one expected reply of the table
  typedef struct packed {
    lpht_pkg::status_e                status;
    logic [lpht_pkg::NAME_W-1:0]      name;
    logic [lpht_pkg::SLOT_W-1:0]      slot;
    logic [lpht_pkg::PROBE_W-1:0]     probes;
  } reply_t;

  // shadow copy of the table plus the queue of replies still owed
  class hash_scoreboard;
    logic [lpht_pkg::KEY_W-1:0]  key_tab [SLOTS];
    logic [lpht_pkg::NAME_W-1:0] name_tab [SLOTS];
    bit                          valid_tab [SLOTS];
    int unsigned                 fill;
    bit                          replace_mode;
    reply_t                      owed_replies [$];
    int                          errors;
    int                          checked;

    function new();
      foreach (valid_tab[i]) valid_tab[i] = 1'b0;
      fill = 0;
      replace_mode = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_mode(logic mode);
      replace_mode = mode;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // walk the shadow table the way the block does and queue the reply
    function void note_request(lpht_pkg::kind_e kind, logic [lpht_pkg::KEY_W-1:0] key,
                               logic [lpht_pkg::NAME_W-1:0] name);
      reply_t                      r;
      int unsigned                 home;
      int unsigned                 pos;
      int unsigned                 placed_at;
      logic [lpht_pkg::KEY_W-1:0]  k;
      logic [lpht_pkg::NAME_W-1:0] n;
      bit                          done;
      r = '0;
      done = 1'b0;
      home = key % SLOTS;
      if (kind == lpht_pkg::KIND_SEARCH) begin
        // full scan from home, empty slots are stepped over
        r.status = lpht_pkg::STAT_NOT_FOUND;
        r.probes = lpht_pkg::PROBE_W'(SLOTS + 1);
        for (int i = 0; i < SLOTS; i++) begin
          pos = (home + i) % SLOTS;
          if (!done && valid_tab[pos] && key_tab[pos] == key) begin
            done = 1'b1;
            r.status = lpht_pkg::STAT_FOUND;
            r.name = name_tab[pos];
            r.slot = lpht_pkg::SLOT_W'(pos);
            r.probes = lpht_pkg::PROBE_W'(i + 1);
          end
        end
      end else if (fill >= SLOTS) begin
        r.status = lpht_pkg::STAT_FULL;
      end else begin
        r.status = lpht_pkg::STAT_INSERTED;
        k = key;
        n = name;
        if (!valid_tab[home]) begin
          key_tab[home] = key;
          name_tab[home] = name;
          valid_tab[home] = 1'b1;
          placed_at = home;
        end else begin
          placed_at = SLOTS;
          // misplaced home occupant gets bumped and re-probed
          if (replace_mode && (key_tab[home] % SLOTS) != home) begin
            k = key_tab[home];
            n = name_tab[home];
            key_tab[home] = key;
            name_tab[home] = name;
            placed_at = home;
          end
          for (int i = 0; i < SLOTS; i++) begin
            pos = (home + i) % SLOTS;
            if (!done && !valid_tab[pos]) begin
              done = 1'b1;
              key_tab[pos] = k;
              name_tab[pos] = n;
              valid_tab[pos] = 1'b1;
              if (placed_at == SLOTS) placed_at = pos;
              r.probes = lpht_pkg::PROBE_W'(i + 1);
            end
          end
        end
        fill++;
        r.slot = lpht_pkg::SLOT_W'(placed_at);
      end
      owed_replies.push_back(r);
    endfunction

    // compare one reply beat with the oldest owed reply
    function void check_reply(logic [1:0] status, logic [lpht_pkg::NAME_W-1:0] name,
                              logic [lpht_pkg::SLOT_W-1:0] slot,
                              logic [lpht_pkg::PROBE_W-1:0] probes);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $error("reply with nothing owed: status %0d slot %0d probes %0d", status, slot, probes);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (name !== want.name) begin
        $error("found_name: expected %h, got %h", want.name, name);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (probes !== want.probes) begin
        $error("probe_count: expected %0d, got %0d", want.probes, probes);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_data_i = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          kind_i = 1'b0;
  logic [lpht_pkg::KEY_W-1:0]    key_i = '0;
  logic [lpht_pkg::NAME_W-1:0]   name_tag_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [1:0]                    status_o;
  logic [lpht_pkg::NAME_W-1:0]   found_name_o;
  logic [lpht_pkg::SLOT_W-1:0]   slot_o;
  logic [lpht_pkg::PROBE_W-1:0]  probe_count_o;

  hash_scoreboard sb = new();
  logic [lpht_pkg::KEY_W-1:0] stored_keys [$];
  bit steady = 1'b0;

  linear_probe_hash_table_core #(
    .TABLE_SIZE(SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .name_tag_i   (name_tag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_name_o (found_name_o),
    .slot_o       (slot_o),
    .probe_count_o(probe_count_o)
  );

  // clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // watch accepted beats on every channel
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.set_mode(cfg_data_i);
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_request(lpht_pkg::kind_e'(kind_i), key_i, name_tag_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply(status_o, found_name_o, slot_o, probe_count_o);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // one request beat; called right after a falling edge
  task automatic send_item(input lpht_pkg::kind_e kind, input logic [lpht_pkg::KEY_W-1:0] key,
                           input logic [lpht_pkg::NAME_W-1:0] name, input int gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    key_i = key;
    name_tag_i = name;
    if (kind == lpht_pkg::KIND_INSERT) stored_keys.push_back(key);
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // sender stops until every owed reply is back
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid_i = 1'b1;
    cfg_data_i = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // random mix; inserts lean toward a few crowded homes
  task automatic send_random(input int count, input int insert_pct);
    logic [lpht_pkg::KEY_W-1:0] key;
    lpht_pkg::kind_e            kind;
    int unsigned                pick;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, 99);
      key = lpht_pkg::KEY_W'($urandom());
      if (pick < insert_pct) begin
        kind = lpht_pkg::KIND_INSERT;
        if ($urandom_range(0, 1))
          key = key - lpht_pkg::KEY_W'(key % SLOTS) + lpht_pkg::KEY_W'($urandom_range(0, 3));
      end else begin
        kind = lpht_pkg::KIND_SEARCH;
        pick = $urandom_range(0, 3);
        if (pick < 2 && stored_keys.size() > 0)
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick == 2 && stored_keys.size() > 0)
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)] +
                lpht_pkg::KEY_W'(SLOTS);
      end
      send_item(kind, key, {$urandom(), $urandom()}, steady ? 0 : pick_gap());
    end
  endtask

  // reply side: random stalls plus one long hold-off
  initial begin
    int  stall;
    bit  held;
    stall = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.checked >= 150) begin
        held = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // request side
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no replacement: home hit, collision, wrap at the table end
    write_mode(1'b0);
    send_item(lpht_pkg::KIND_INSERT, 31'd3, 64'd0, 0);
    send_item(lpht_pkg::KIND_INSERT, 31'd19, '1, 0);
    send_item(lpht_pkg::KIND_INSERT, '1, 64'h0123_4567_89ab_cdef, 2);
    send_item(lpht_pkg::KIND_INSERT, 31'd31, 64'hfeed_0000_0000_0031, 0);
    send_item(lpht_pkg::KIND_SEARCH, 31'd19, '0, 1);
    send_item(lpht_pkg::KIND_SEARCH, 31'd35, '1, 0);
    send_item(lpht_pkg::KIND_SEARCH, 31'd0, '0, 0);
    send_item(lpht_pkg::KIND_SEARCH, '1, '0, 3);

    // replacement: misplaced occupants bumped, own-home occupant kept, duplicate key
    wait_idle();
    write_mode(1'b1);
    send_item(lpht_pkg::KIND_INSERT, 31'd4, 64'h4444_4444_4444_4444, 0);
    send_item(lpht_pkg::KIND_INSERT, 31'd16, 64'h1616_1616_1616_1616, 0);
    send_item(lpht_pkg::KIND_INSERT, 31'd35, 64'h3535_3535_3535_3535, 1);
    send_item(lpht_pkg::KIND_INSERT, 31'd3, 64'hd00d_d00d_d00d_d00d, 0);
    send_item(lpht_pkg::KIND_SEARCH, 31'd3, '0, 0);
    send_item(lpht_pkg::KIND_SEARCH, 31'd19, '0, 0);
    send_item(lpht_pkg::KIND_SEARCH, 31'd31, '0, 2);
    send_item(lpht_pkg::KIND_SEARCH, 31'd4, 64'h5a5a_a5a5_5a5a_a5a5, 0);

    // fill the rest of the table and run into full
    send_random(40, 70);

    wait_idle();
    write_mode(1'b0);
    send_random(450, 15);

    wait_idle();
    write_mode(1'b1);
    steady = 1'b1;
    send_random(450, 15);
    steady = 1'b0;

    wait_idle();
    write_mode(1'b0);
    send_random(450, 15);

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(2 * HALF_PERIOD * 1_000_000);
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table_core.sv
sim/tb_top.sv
